>>> hw/rtl/tbt_pkg.sv
// shared types, widths and helpers for the triangle tangent / bitangent block
// used by every module of the block; depends on nothing
package tbt_pkg;

   localparam int INDEX_WIDTH     = 24;
   localparam int Q_WIDTH         = 32;
   localparam int REQ_FIELD_BITS  = 5 * Q_WIDTH + INDEX_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS  = 6 * Q_WIDTH + 3 * INDEX_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [Q_WIDTH-1:0] Q_MAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
   localparam logic [Q_WIDTH-1:0] Q_MIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [Q_WIDTH-1:0]     q_type;

   typedef struct packed {
      q_type [2:0] dp1;
      q_type [2:0] dp2;
      q_type       du1;
      q_type       dv1;
      q_type       du2;
      q_type       dv2;
      index_type   corner_a;
      index_type   corner_b;
      index_type   corner_c;
   } job_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } link_type;

   function automatic q_type sat_delta(input logic signed [Q_WIDTH:0] d);
      q_type r;
      if (d[Q_WIDTH] != d[Q_WIDTH-1]) begin
         r = d[Q_WIDTH] ? Q_MIN : Q_MAX;
      end else begin
         r = d[Q_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/tbt_front.sv
// front end: collects the corners of a triangle and forms the saturated edge deltas
// depends on tbt_pkg
module tbt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbt_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output tbt_pkg::link_type                   job_link_out,
   input  logic                                job_ready,
   output tbt_pkg::job_type                    job
);
   import tbt_pkg::*;

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;

   logic [1:0] slot_ff, slot_in;
   q_type      held_p0_ff [3];
   q_type      held_p1_ff [3];
   q_type      held_u0_ff, held_v0_ff, held_u1_ff, held_v1_ff;
   index_type  held_i0_ff, held_i1_ff;

   q_type      pos [3];
   q_type      tex_u, tex_v;
   index_type  vertex_index;
   logic       is_third, accept;

   assign pos[0]       = req_tdata[31:0];
   assign pos[1]       = req_tdata[63:32];
   assign pos[2]       = req_tdata[95:64];
   assign tex_u        = req_tdata[127:96];
   assign tex_v        = req_tdata[159:128];
   assign vertex_index = req_tdata[160 +: INDEX_WIDTH];

   assign is_third   = (slot_ff == SLOT_THIRD);
   assign req_tready = !is_third || job_ready;
   assign accept     = req_tvalid && req_tready;

   assign job_link_out.valid = req_tvalid && is_third;
   assign job_link_out.ready = job_ready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         job.dp1[k] = sat_delta({held_p1_ff[k][31], held_p1_ff[k]}
                                - {held_p0_ff[k][31], held_p0_ff[k]});
         job.dp2[k] = sat_delta({pos[k][31], pos[k]} - {held_p0_ff[k][31], held_p0_ff[k]});
      end
      job.du1      = sat_delta({held_u1_ff[31], held_u1_ff} - {held_u0_ff[31], held_u0_ff});
      job.dv1      = sat_delta({held_v1_ff[31], held_v1_ff} - {held_v0_ff[31], held_v0_ff});
      job.du2      = sat_delta({tex_u[31], tex_u} - {held_u0_ff[31], held_u0_ff});
      job.dv2      = sat_delta({tex_v[31], tex_v} - {held_v0_ff[31], held_v0_ff});
      job.corner_a = held_i0_ff;
      job.corner_b = held_i1_ff;
      job.corner_c = vertex_index;
   end

   always_comb begin
      slot_in = slot_ff;
      if (accept) begin
         case (slot_ff)
            SLOT_SECOND: slot_in = SLOT_THIRD;
            SLOT_THIRD:  slot_in = SLOT_FIRST;
            default:     slot_in = SLOT_SECOND;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_FIRST;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && slot_ff == SLOT_SECOND) begin
         held_p1_ff <= pos;
         held_u1_ff <= tex_u;
         held_v1_ff <= tex_v;
         held_i1_ff <= vertex_index;
      end
      if (accept && slot_ff != SLOT_SECOND && slot_ff != SLOT_THIRD) begin
         held_p0_ff <= pos;
         held_u0_ff <= tex_u;
         held_v0_ff <= tex_v;
         held_i0_ff <= vertex_index;
      end
   end

endmodule

>>> hw/rtl/tbt_queue.sv
// two-entry queue of triangle jobs between front and back end
// depends on tbt_pkg
module tbt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tbt_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output tbt_pkg::job_type out_job
);
   import tbt_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

>>> hw/rtl/tbt_back.sv
// back end: shared multiplier for determinant and numerators, bit-serial divider,
// output register; depends on tbt_pkg
module tbt_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   output logic                                job_ready,
   input  tbt_pkg::job_type                    job,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbt_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tuser
);
   import tbt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DLOAD = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [3:0] MUL_LAST = 4'd13;
   localparam logic [6:0] DIV_LAST = 7'd79;
   localparam logic [2:0] SEL_LAST = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   job_type            job_ff, job_in;
   logic [3:0]         mul_idx_ff, mul_idx_in;
   logic               phase_ff, phase_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [63:0] num_ff [7];
   logic signed [63:0] num_in [7];
   logic [2:0]         sel_ff, sel_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [79:0]        sh_ff, sh_in;
   logic [63:0]        rem_ff, rem_in, den_ff, den_in;
   logic [32:0]        quo_ff, quo_in;
   logic               ovf_ff, ovf_in, neg_ff, neg_in;
   q_type              res_ff [6];
   q_type              res_in [6];
   q_type              out_res_ff [6];
   q_type              out_res_in [6];
   logic               out_degen_ff, out_degen_in;
   index_type          out_a_ff, out_a_in, out_b_ff, out_b_in, out_c_ff, out_c_in;

   logic signed [31:0] op_a, op_b;
   logic signed [63:0] numer, denom;
   logic [64:0]        trial, diff;
   logic               ge, big, degen;
   q_type              quot;

   assign job_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_degen_ff;
   assign degen      = (num_ff[0] == 64'sd0);

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 6; k++) begin
         rsp_tdata[k*32 +: 32] = out_res_ff[k];
      end
      rsp_tdata[192 +: INDEX_WIDTH]                 = out_a_ff;
      rsp_tdata[192 + INDEX_WIDTH +: INDEX_WIDTH]   = out_b_ff;
      rsp_tdata[192 + 2*INDEX_WIDTH +: INDEX_WIDTH] = out_c_ff;
   end

   always_comb begin
      case (mul_idx_ff)
         4'd0:    begin op_a = job_ff.du1;    op_b = job_ff.dv2; end
         4'd1:    begin op_a = job_ff.dv1;    op_b = job_ff.du2; end
         4'd2:    begin op_a = job_ff.dp1[0]; op_b = job_ff.dv2; end
         4'd3:    begin op_a = job_ff.dp2[0]; op_b = job_ff.dv1; end
         4'd4:    begin op_a = job_ff.dp1[1]; op_b = job_ff.dv2; end
         4'd5:    begin op_a = job_ff.dp2[1]; op_b = job_ff.dv1; end
         4'd6:    begin op_a = job_ff.dp1[2]; op_b = job_ff.dv2; end
         4'd7:    begin op_a = job_ff.dp2[2]; op_b = job_ff.dv1; end
         4'd8:    begin op_a = job_ff.dp2[0]; op_b = job_ff.du1; end
         4'd9:    begin op_a = job_ff.dp1[0]; op_b = job_ff.du2; end
         4'd10:   begin op_a = job_ff.dp2[1]; op_b = job_ff.du1; end
         4'd11:   begin op_a = job_ff.dp1[1]; op_b = job_ff.du2; end
         4'd12:   begin op_a = job_ff.dp2[2]; op_b = job_ff.du1; end
         4'd13:   begin op_a = job_ff.dp1[2]; op_b = job_ff.du2; end
         default: begin op_a = '0;            op_b = '0;         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      job_in       = job_ff;
      mul_idx_in   = mul_idx_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      out_res_in   = out_res_ff;
      out_degen_in = out_degen_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_c_in     = out_c_ff;

      numer = num_ff[sel_ff + 3'd1];
      denom = num_ff[0];
      trial = {rem_ff, sh_ff[79]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
      big   = ovf_ff || quo_ff[32] || quo_ff[31];
      quot  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in     = job;
               mul_idx_in = 4'd0;
               phase_in   = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!phase_ff) begin
               prod_in  = op_a * op_b;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!mul_idx_ff[0]) begin
                  acc_in = prod_ff;
               end else begin
                  num_in[mul_idx_ff[3:1]] = acc_ff - prod_ff;
               end
               mul_idx_in = mul_idx_ff + 4'd1;
               if (mul_idx_ff == MUL_LAST) begin
                  sel_in   = 3'd0;
                  state_in = degen ? ST_DONE : ST_DLOAD;
               end
            end
         end
         ST_DLOAD: begin
            neg_in   = numer[63] ^ denom[63];
            sh_in    = {(numer[63] ? 64'd0 - numer : numer), 16'd0};
            den_in   = denom[63] ? 64'd0 - denom : denom;
            rem_in   = '0;
            quo_in   = '0;
            ovf_in   = 1'b0;
            cnt_in   = 7'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == DIV_LAST + 7'd1) begin
               if (neg_ff) begin
                  quot = big ? Q_MIN : 32'd0 - quo_ff[31:0];
               end else begin
                  quot = big ? Q_MAX : quo_ff[31:0];
               end
               res_in[sel_ff] = quot;
               if (sel_ff == SEL_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  sel_in   = sel_ff + 3'd1;
                  state_in = ST_DLOAD;
               end
            end else begin
               rem_in = ge ? diff[63:0] : trial[63:0];
               quo_in = {quo_ff[31:0], ge};
               ovf_in = ovf_ff || quo_ff[32];
               sh_in  = {sh_ff[78:0], 1'b0};
               cnt_in = cnt_ff + 7'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               for (int k = 0; k < 6; k++) begin
                  out_res_in[k] = degen ? '0 : res_ff[k];
               end
               out_degen_in = degen;
               out_a_in     = job_ff.corner_a;
               out_b_in     = job_ff.corner_b;
               out_c_in     = job_ff.corner_c;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      mul_idx_ff   <= mul_idx_in;
      phase_ff     <= phase_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      sel_ff       <= sel_in;
      cnt_ff       <= cnt_in;
      sh_ff        <= sh_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      ovf_ff       <= ovf_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      out_res_ff   <= out_res_in;
      out_degen_ff <= out_degen_in;
      out_a_ff     <= out_a_in;
      out_b_ff     <= out_b_in;
      out_c_ff     <= out_c_in;
   end

endmodule

>>> hw/rtl/triangle_tangent_bitangent.sv
// top level of the per-triangle tangent / bitangent block
// depends on tbt_pkg, tbt_front, tbt_queue, tbt_back
//
// usage:
//   req channel: one vertex per item, triangles in corner order a, b, c.
//   every third accepted vertex yields one item on the rsp channel with the
//   tangent, bitangent, degenerate flag (rsp_tuser) and the three vertex indices.
//   the first two corners are always taken; the third is taken as soon as the
//   two-entry job queue has room.
//   the back end picks up a job, forms the fourteen products on its single
//   32x32 multiplier, then for each of the six quotients loads and runs the
//   one-bit-a-cycle divider (skipped for a zero determinant) and finally loads
//   the output register; it takes a new job only when back in idle, and the
//   divider sets the sustained rate.
//   a stalled rsp_tready holds the result in the output register; the back end
//   then waits, the queue fills and finally req_tready drops on a third corner.
//   synchronous reset restarts at the first corner and empties queue and output.
module triangle_tangent_bitangent (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index
   input  logic [tbt_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tan_x, tan_y, tan_z, bit_x, bit_y, bit_z, corner_a, corner_b, corner_c
   output logic [tbt_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // degenerate
   output logic                                rsp_tuser
);
   import tbt_pkg::*;

   link_type front_link;
   job_type  front_job, back_job;
   logic     q_in_ready, q_out_valid, back_ready;

   tbt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .job_link_out (front_link),
      .job_ready    (q_in_ready),
      .job          (front_job)
   );

   tbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_link.valid),
      .in_ready  (q_in_ready),
      .in_job    (front_job),
      .out_valid (q_out_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   tbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_out_valid),
      .job_ready  (back_ready),
      .job        (back_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hw/rtl/tbt_checker.sv
// port-level checks for triangle_tangent_bitangent, bound to the top level
// depends on tbt_pkg
module tbt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tbt_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic                                rsp_tuser
);
   import tbt_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[6*Q_WIDTH-1:0] == '0)
      else $error("degenerate item with nonzero vectors");

endmodule

bind triangle_tangent_bitangent tbt_checker u_tbt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
